/* hw/rtl/ocig_pkg.sv */
// ----------------------------------------------------------------------------
// ocig_pkg: shared definitions for the OLED controller graphics RAM block
// Panel geometry, graphics RAM addressing, item kinds and the RAM write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ocig_pkg;

	// Panel geometry: 8 pages of 8 rows, WIDTH columns (16 to 128)
	localparam int WIDTH     = 128;
	localparam int PAGES     = 8;
	localparam int PAGE_W    = 3;
	localparam int COL_W     = 7;
	localparam int RAM_DEPTH = PAGES * WIDTH;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);

	localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(WIDTH - 1);
	localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(RAM_DEPTH - 1);

	// Kind of an input item (carried in tuser)
	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_STOP  = 2'd1,
		MODE_BYTE  = 2'd2,
		MODE_READ  = 2'd3
	} item_mode_t;

	// Write request into the graphics RAM
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} gram_wr_t;

	// Byte address of page p, column c
	function automatic logic [ADDR_W-1:0] gram_addr(
		input logic [PAGE_W-1:0] page,
		input logic [COL_W-1:0]  col
	);
		gram_addr = ADDR_W'(page) * ADDR_W'(WIDTH) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/ocig_gram.sv */
// ----------------------------------------------------------------------------
// ocig_gram: graphics RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ocig_gram (
	input  wire logic                        clk,
	input  var  ocig_pkg::gram_wr_t          wr,
	input  wire logic                        rd_en,
	input  wire logic [ocig_pkg::ADDR_W-1:0] rd_addr,
	output logic      [7:0]                  rd_data
);

	logic [7:0] mem [ocig_pkg::RAM_DEPTH];

	// Write the requested byte
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read and hold until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ocig_ctrl.sv */
// ----------------------------------------------------------------------------
// ocig_ctrl: bus parser and command decoder
// Tracks the bus phase, decodes commands and parameters, keeps the column and
// page pointers with their windows and issues graphics RAM writes for data.
// ----------------------------------------------------------------------------
`default_nettype none

module ocig_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_fire,
	input  wire logic [1:0]           mode,
	input  wire logic [7:0]           bus_byte,
	output ocig_pkg::gram_wr_t        wr,
	output logic                      disp_next,
	output logic                      inv_next
);

	localparam int COL_W  = ocig_pkg::COL_W;
	localparam int PAGE_W = ocig_pkg::PAGE_W;

	localparam logic [7:0] WIDTH_B = 8'(ocig_pkg::WIDTH);

	// Command opcodes
	localparam logic [7:0] CMD_NONE      = 8'h00;
	localparam logic [7:0] CMD_ADDR_MODE = 8'h20;
	localparam logic [7:0] CMD_COL_WIN   = 8'h21;
	localparam logic [7:0] CMD_PAGE_WIN  = 8'h22;
	localparam logic [7:0] CMD_CONTRAST  = 8'h81;
	localparam logic [7:0] CMD_CHG_PUMP  = 8'h8D;
	localparam logic [7:0] CMD_NORMAL    = 8'hA6;
	localparam logic [7:0] CMD_INVERSE   = 8'hA7;
	localparam logic [7:0] CMD_MUX_RATIO = 8'hA8;
	localparam logic [7:0] CMD_DISP_OFF  = 8'hAE;
	localparam logic [7:0] CMD_DISP_ON   = 8'hAF;
	localparam logic [7:0] CMD_OFFSET    = 8'hD3;
	localparam logic [7:0] CMD_CLK_DIV   = 8'hD5;
	localparam logic [7:0] CMD_PRECHARGE = 8'hD9;
	localparam logic [7:0] CMD_COM_PINS  = 8'hDA;
	localparam logic [7:0] CMD_VCOMH     = 8'hDB;

	// Addressing modes
	localparam logic [1:0] AM_HORZ = 2'd0;
	localparam logic [1:0] AM_VERT = 2'd1;
	localparam logic [1:0] AM_PAGE = 2'd2;

	// Upper opcode bits of the command groups
	localparam logic [4:0] PAGE_CMD_HI       = 5'b10110;
	localparam logic [3:0] COL_LO_CMD_HI     = 4'h0;
	localparam logic [3:0] COL_HI_CMD_HI     = 4'h1;
	localparam logic [1:0] START_LINE_CMD_HI = 2'b01;

	typedef enum logic [1:0] {
		PH_ADDR    = 2'd0,
		PH_CTRL    = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [PAGE_W-1:0]   page_q, page_d;
	logic [COL_W-1:0]    cws_q, cws_d, cwe_q, cwe_d;
	logic [PAGE_W-1:0]   pws_q, pws_d, pwe_q, pwe_d;
	logic [1:0]          amode_q, amode_d;
	logic                disp_q, disp_d, inv_q, inv_d;
	logic [7:0]          pend_q, pend_d, fparam_q, fparam_d;
	logic                pcnt_q, pcnt_d;
	logic                is_data_q, is_data_d, cont_q, cont_d;
	logic [7:0]          hi_col;
	logic                has_param;

	assign hi_col = {bus_byte[3:0], 1'b0, col_q[2:0]} | {4'h0, col_q[3], 3'b000};

	always_comb begin
		case (bus_byte)
			CMD_ADDR_MODE, CMD_COL_WIN, CMD_PAGE_WIN, CMD_CONTRAST, CMD_CHG_PUMP,
			CMD_MUX_RATIO, CMD_OFFSET, CMD_CLK_DIV, CMD_PRECHARGE, CMD_COM_PINS,
			CMD_VCOMH: has_param = 1'b1;
			default:   has_param = 1'b0;
		endcase
	end

	// Next state for one accepted item
	always_comb begin
		phase_d   = phase_q;
		col_d     = col_q;
		page_d    = page_q;
		cws_d     = cws_q;
		cwe_d     = cwe_q;
		pws_d     = pws_q;
		pwe_d     = pwe_q;
		amode_d   = amode_q;
		disp_d    = disp_q;
		inv_d     = inv_q;
		pend_d    = pend_q;
		fparam_d  = fparam_q;
		pcnt_d    = pcnt_q;
		is_data_d = is_data_q;
		cont_d    = cont_q;
		wr        = '0;

		if (item_fire) begin
			case (ocig_pkg::item_mode_t'(mode))
				ocig_pkg::MODE_START, ocig_pkg::MODE_STOP: begin
					phase_d = PH_ADDR;
				end
				ocig_pkg::MODE_BYTE: begin
					case (phase_q)
						PH_ADDR: begin
							phase_d = PH_CTRL;
						end
						PH_CTRL: begin
							is_data_d = bus_byte[6];
							cont_d    = bus_byte[7];
							phase_d   = PH_PAYLOAD;
						end
						default: begin
							if (is_data_q) begin
								// Store data and advance the pointers
								if (col_q <= ocig_pkg::COL_MAX) begin
									wr.en   = 1'b1;
									wr.addr = ocig_pkg::gram_addr(page_q, col_q);
									wr.data = bus_byte;
									if (amode_q == AM_VERT) begin
										if (page_q >= pwe_q) begin
											page_d = pws_q;
											col_d  = (col_q >= cwe_q) ? cws_q : col_q + 1'b1;
										end else begin
											page_d = page_q + 1'b1;
										end
									end else begin
										if (col_q >= cwe_q) begin
											col_d = cws_q;
											if (amode_q == AM_HORZ) begin
												page_d = (page_q >= pwe_q) ? pws_q : page_q + 1'b1;
											end
										end else begin
											col_d = col_q + 1'b1;
										end
									end
								end
							end else if (pend_q != CMD_NONE) begin
								// Collect a parameter of the pending command
								if (pend_q == CMD_COL_WIN || pend_q == CMD_PAGE_WIN) begin
									if (!pcnt_q) begin
										fparam_d = bus_byte;
										pcnt_d   = 1'b1;
									end else begin
										if (pend_q == CMD_COL_WIN) begin
											cws_d = (fparam_q < WIDTH_B) ? fparam_q[COL_W-1:0] : '0;
											cwe_d = (bus_byte < WIDTH_B) ? bus_byte[COL_W-1:0]
											                             : ocig_pkg::COL_MAX;
											col_d = cws_d;
										end else begin
											pws_d  = fparam_q[PAGE_W-1:0];
											pwe_d  = bus_byte[PAGE_W-1:0];
											page_d = pws_d;
										end
										pend_d = CMD_NONE;
										pcnt_d = 1'b0;
									end
								end else begin
									if (pend_q == CMD_ADDR_MODE) begin
										amode_d = bus_byte[1:0];
									end
									pend_d = CMD_NONE;
									pcnt_d = 1'b0;
								end
							end else if (bus_byte == CMD_DISP_OFF) begin
								disp_d = 1'b0;
							end else if (bus_byte == CMD_DISP_ON) begin
								disp_d = 1'b1;
							end else if (bus_byte[7:3] == PAGE_CMD_HI) begin
								page_d = bus_byte[PAGE_W-1:0];
								col_d  = cws_q;
							end else if (bus_byte[7:4] == COL_LO_CMD_HI) begin
								col_d = {col_q[COL_W-1:4], bus_byte[3:0]};
							end else if (bus_byte[7:4] == COL_HI_CMD_HI) begin
								col_d = (hi_col >= WIDTH_B) ? ocig_pkg::COL_MAX
								                            : hi_col[COL_W-1:0];
							end else if (bus_byte[7:6] == START_LINE_CMD_HI) begin
								// Start line: ignore
							end else if (bus_byte == CMD_NORMAL) begin
								inv_d = 1'b0;
							end else if (bus_byte == CMD_INVERSE) begin
								inv_d = 1'b1;
							end else if (has_param) begin
								pend_d = bus_byte;
								pcnt_d = 1'b0;
							end
							if (cont_q) begin
								phase_d = PH_CTRL;
							end
						end
					endcase
				end
				default: begin
					// Pixel read leaves the control state alone
				end
			endcase
		end
	end

	assign disp_next = disp_d;
	assign inv_next  = inv_d;

	// Hold the control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ADDR;
			col_q     <= '0;
			page_q    <= '0;
			cws_q     <= '0;
			cwe_q     <= ocig_pkg::COL_MAX;
			pws_q     <= '0;
			pwe_q     <= '1;
			amode_q   <= AM_PAGE;
			disp_q    <= 1'b0;
			inv_q     <= 1'b0;
			pend_q    <= CMD_NONE;
			fparam_q  <= '0;
			pcnt_q    <= 1'b0;
			is_data_q <= 1'b0;
			cont_q    <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			col_q     <= col_d;
			page_q    <= page_d;
			cws_q     <= cws_d;
			cwe_q     <= cwe_d;
			pws_q     <= pws_d;
			pwe_q     <= pwe_d;
			amode_q   <= amode_d;
			disp_q    <= disp_d;
			inv_q     <= inv_d;
			pend_q    <= pend_d;
			fparam_q  <= fparam_d;
			pcnt_q    <= pcnt_d;
			is_data_q <= is_data_d;
			cont_q    <= cont_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/oled_controller_i2c_gram_top.sv */
// ----------------------------------------------------------------------------
// oled_controller_i2c_gram_top: OLED panel controller with graphics RAM
// Pipeline: an accepted item passes the RAM read stage, then the output
// register. Throughput: one item per cycle while the output is not stalled;
// the single graphics RAM port pair sets it. Reset: control state clears at
// once; a clearing pass then zeroes all RAM_DEPTH bytes of the graphics RAM
// (1024 at WIDTH 128), with s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module oled_controller_i2c_gram_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // bus_byte[7:0], read_x[14:8], read_y[20:15], zeros
	input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata   // pixel_on[0], panel_enabled[1], invert_active[2], zeros
);

	localparam int ADDR_W = ocig_pkg::ADDR_W;
	localparam logic [7:0] WIDTH_B = 8'(ocig_pkg::WIDTH);

	logic [7:0]        bus_byte;
	logic [6:0]        read_x;
	logic [5:0]        read_y;
	logic              s_fire, rd_en, out_free, s1_adv;
	logic              disp_next, inv_next;
	ocig_pkg::gram_wr_t ctrl_wr, gram_wr;
	logic [7:0]        rd_data;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic              valid_s1, is_read_s1, in_range_s1, disp_s1, inv_s1;
	logic [2:0]        bit_s1;
	logic              out_valid_q, pix_q, disp_q, inv_q;
	logic [7:0]        stored;

	assign bus_byte = s_axis_tdata[7:0];
	assign read_x   = s_axis_tdata[14:8];
	assign read_y   = s_axis_tdata[20:15];

	// Handshake and stage advance
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_adv        = valid_s1 && out_free;
	assign s_axis_tready = !clr_busy_q && (!valid_s1 || out_free);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign rd_en         = s_fire && (s_axis_tuser == ocig_pkg::MODE_READ);

	ocig_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (s_fire),
		.mode      (s_axis_tuser),
		.bus_byte  (bus_byte),
		.wr        (ctrl_wr),
		.disp_next (disp_next),
		.inv_next  (inv_next)
	);

	// Clearing pass owns the write port after reset
	always_comb begin
		if (clr_busy_q) begin
			gram_wr.en   = 1'b1;
			gram_wr.addr = clr_addr_q;
			gram_wr.data = '0;
		end else begin
			gram_wr = ctrl_wr;
		end
	end

	ocig_gram u_gram (
		.clk     (clk),
		.wr      (gram_wr),
		.rd_en   (rd_en),
		.rd_addr (ocig_pkg::gram_addr(read_y[5:3], read_x)),
		.rd_data (rd_data)
	);

	// Sweep the RAM once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == ocig_pkg::ADDR_MAX) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Stage 1: item waits for its RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			is_read_s1  <= (s_axis_tuser == ocig_pkg::MODE_READ);
			in_range_s1 <= ({1'b0, read_x} < WIDTH_B);
			bit_s1      <= read_y[2:0];
			disp_s1     <= disp_next;
			inv_s1      <= inv_next;
		end
	end

	// Apply the on and invert rules
	assign stored = in_range_s1 ? rd_data : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pix_q  <= is_read_s1 && disp_s1 && (stored[bit_s1] ^ inv_s1);
			disp_q <= disp_s1;
			inv_q  <= inv_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, inv_q, disp_q, pix_q};

	// No item enters while the clearing pass runs
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_fire)
		else $error("item accepted during graphics RAM clear");

	// Clearing pass runs only once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("graphics RAM clear restarted");

	// A stalled stage-1 item is never dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> valid_s1)
		else $error("stage-1 item lost while output stalled");

	// A dark panel shows no lit pixel
	a_dark_panel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[1]) |-> !m_axis_tdata[0])
		else $error("pixel lit while display is off");

endmodule

`default_nettype wire

/* test/oled_controller_i2c_gram_top_tb.sv */
// ----------------------------------------------------------------------------
// oled_controller_i2c_gram_top_tb: self-checking bench for the OLED controller
// Drives bus start/stop/byte events and pixel reads into the slave stream and
// checks every result item against a cycle-free model of the controller
// (pointer walk, command decoder, graphics RAM and display flags). A directed
// table comes first, then random transactions under several idling patterns.
// ----------------------------------------------------------------------------

module oled_controller_i2c_gram_top_tb;

	// Panel geometry
	localparam int               WIDTH     = ocig_pkg::WIDTH;
	localparam int               COL_W     = ocig_pkg::COL_W;
	localparam int               PAGE_W    = ocig_pkg::PAGE_W;
	localparam int               RAM_DEPTH = ocig_pkg::RAM_DEPTH;
	localparam logic [COL_W-1:0] COL_MAX   = ocig_pkg::COL_MAX;

	// Command opcodes
	localparam logic [7:0] OP_NONE        = 8'h00;
	localparam logic [7:0] OP_COL_LO_BASE = 8'h00;
	localparam logic [7:0] OP_COL_HI_BASE = 8'h10;
	localparam logic [7:0] OP_ADDR_MODE   = 8'h20;
	localparam logic [7:0] OP_COL_WINDOW  = 8'h21;
	localparam logic [7:0] OP_PAGE_WINDOW = 8'h22;
	localparam logic [7:0] OP_START_LINE  = 8'h40;
	localparam logic [7:0] OP_CONTRAST    = 8'h81;
	localparam logic [7:0] OP_CHARGE_PUMP = 8'h8D;
	localparam logic [7:0] OP_NORMAL      = 8'hA6;
	localparam logic [7:0] OP_INVERSE     = 8'hA7;
	localparam logic [7:0] OP_MUX_RATIO   = 8'hA8;
	localparam logic [7:0] OP_DISPLAY_OFF = 8'hAE;
	localparam logic [7:0] OP_DISPLAY_ON  = 8'hAF;
	localparam logic [7:0] OP_PAGE_BASE   = 8'hB0;
	localparam logic [7:0] OP_DISP_OFFSET = 8'hD3;
	localparam logic [7:0] OP_CLOCK_DIV   = 8'hD5;
	localparam logic [7:0] OP_PRECHARGE   = 8'hD9;
	localparam logic [7:0] OP_COM_PINS    = 8'hDA;
	localparam logic [7:0] OP_VCOMH       = 8'hDB;

	// Control byte layout and common values
	localparam int         CTRL_DATA_BIT  = 6;
	localparam int         CTRL_CONT_BIT  = 7;
	localparam logic [7:0] CTRL_CMD       = 8'h00;
	localparam logic [7:0] CTRL_CMD_CONT  = 8'h80;
	localparam logic [7:0] CTRL_DATA_CONT = 8'hC0;
	localparam logic [7:0] BUS_ADDR       = 8'h78;

	// Addressing modes
	localparam logic [1:0] AM_HORIZONTAL = 2'd0;
	localparam logic [1:0] AM_VERTICAL   = 2'd1;
	localparam logic [1:0] AM_PAGE       = 2'd2;

	// Bus phases
	localparam logic [1:0] PH_ADDRESS = 2'd0;
	localparam logic [1:0] PH_CONTROL = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	localparam int ITEMS_PER_PHASE = 345;
	localparam int LONG_HOLD       = 400;

	typedef struct packed {
		logic pix;
		logic en;
		logic inv;
	} pixel_status_t;

	typedef struct packed {
		ocig_pkg::item_mode_t m;
		logic [7:0]           b;
		logic [6:0]           x;
		logic [5:0]           y;
		logic                 typed;
		pixel_status_t        want;   // pix, en, inv
	} stim_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;

	oled_controller_i2c_gram_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Controller image kept by the bench
	logic [7:0]        gram_img [RAM_DEPTH];
	logic [COL_W-1:0]  col_ptr      = '0;
	logic [COL_W-1:0]  col_lo       = '0;
	logic [COL_W-1:0]  col_hi       = COL_MAX;
	logic [PAGE_W-1:0] page_ptr     = '0;
	logic [PAGE_W-1:0] page_lo      = '0;
	logic [PAGE_W-1:0] page_hi      = 3'd7;
	logic [1:0]        scan_mode    = AM_PAGE;
	logic              disp_on      = 1'b0;
	logic              disp_inv     = 1'b0;
	logic [7:0]        pend_op      = OP_NONE;
	logic [7:0]        first_arg    = 8'h00;
	logic              arg_count    = 1'b0;
	logic [1:0]        link_phase   = PH_ADDRESS;
	logic              payload_data = 1'b0;
	logic              ctrl_repeat  = 1'b0;

	pixel_status_t expected_status [$];
	logic [7:0]    cmd_bytes [$];

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_cycles  = 0;
	int items_sent   = 0;
	int bytes_sent   = 0;
	int reads_sent   = 0;
	int framing_sent = 0;
	int results_seen = 0;
	int lit_pixels   = 0;
	int error_count  = 0;

	// Directed items: reset state, display flags, column window clamps with a
	// stop/start between its two arguments, column high nibble clamp, corner reads
	stim_row_t directed_rows [25] = '{
		'{ocig_pkg::MODE_READ,  8'h00,          7'd0,   6'd0,  1'b1, 3'b000},
		'{ocig_pkg::MODE_READ,  8'hFF,          7'd127, 6'd63, 1'b1, 3'b000},
		'{ocig_pkg::MODE_START, 8'hFF,          7'd127, 6'd63, 1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  BUS_ADDR,       7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  CTRL_CMD_CONT,  7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  OP_DISPLAY_ON,  7'd0,   6'd0,  1'b1, 3'b010},
		'{ocig_pkg::MODE_BYTE,  CTRL_CMD,       7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  OP_INVERSE,     7'd0,   6'd0,  1'b1, 3'b011},
		'{ocig_pkg::MODE_BYTE,  OP_COL_WINDOW,  7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  8'hFF,          7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_STOP,  8'h5A,          7'd85,  6'd42, 1'b0, 3'b000},
		'{ocig_pkg::MODE_START, 8'hA5,          7'd42,  6'd21, 1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  BUS_ADDR,       7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  CTRL_CMD,       7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  8'h85,          7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  OP_ADDR_MODE,   7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  {6'b000000, AM_HORIZONTAL}, 7'd0, 6'd0, 1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  OP_COL_HI_BASE | 8'h0F, 7'd0, 6'd0, 1'b0, 3'b000},
		'{ocig_pkg::MODE_STOP,  8'h00,          7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_START, 8'h00,          7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  BUS_ADDR,       7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  CTRL_DATA_CONT, 7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_BYTE,  8'hFF,          7'd0,   6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_READ,  8'h00,          7'd127, 6'd0,  1'b0, 3'b000},
		'{ocig_pkg::MODE_READ,  8'h00,          7'd127, 6'd63, 1'b0, 3'b000}
	};

	// Clock
	initial begin
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

	task automatic flag_error(string msg);
		error_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------- model

	function automatic bit takes_argument(logic [7:0] v);
		case (v)
			OP_ADDR_MODE, OP_COL_WINDOW, OP_PAGE_WINDOW, OP_CONTRAST, OP_CHARGE_PUMP,
			OP_MUX_RATIO, OP_DISP_OFFSET, OP_CLOCK_DIV, OP_PRECHARGE, OP_COM_PINS,
			OP_VCOMH: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Write one data byte and walk the pointers inside the windows
	function automatic void store_pixel_byte(logic [7:0] v);
		if (int'(col_ptr) > WIDTH - 1)
			return;
		gram_img[int'(page_ptr) * WIDTH + int'(col_ptr)] = v;
		if (scan_mode == AM_VERTICAL) begin
			if (page_ptr >= page_hi) begin
				page_ptr = page_lo;
				col_ptr  = (col_ptr >= col_hi) ? col_lo : col_ptr + 1'b1;
			end else begin
				page_ptr = page_ptr + 1'b1;
			end
		end else if (col_ptr >= col_hi) begin
			col_ptr = col_lo;
			if (scan_mode == AM_HORIZONTAL)
				page_ptr = (page_ptr >= page_hi) ? page_lo : page_ptr + 1'b1;
		end else begin
			col_ptr = col_ptr + 1'b1;
		end
	endfunction

	// Collect an argument of the pending command; apply it once complete
	function automatic void take_argument(logic [7:0] v);
		if ((pend_op == OP_COL_WINDOW || pend_op == OP_PAGE_WINDOW) && !arg_count) begin
			first_arg = v;
			arg_count = 1'b1;
			return;
		end
		if (pend_op == OP_COL_WINDOW) begin
			col_lo  = (int'(first_arg) < WIDTH) ? COL_W'(first_arg) : '0;
			col_hi  = (int'(v) < WIDTH) ? COL_W'(v) : COL_MAX;
			col_ptr = col_lo;
		end else if (pend_op == OP_PAGE_WINDOW) begin
			page_lo  = first_arg[PAGE_W-1:0];
			page_hi  = v[PAGE_W-1:0];
			page_ptr = page_lo;
		end else if (pend_op == OP_ADDR_MODE) begin
			scan_mode = v[1:0];
		end
		pend_op   = OP_NONE;
		arg_count = 1'b0;
	endfunction

	function automatic void run_command(logic [7:0] v);
		logic [7:0] hi_col;
		if (pend_op != OP_NONE) begin
			take_argument(v);
			return;
		end
		if (v == OP_DISPLAY_OFF) begin
			disp_on = 1'b0;
		end else if (v == OP_DISPLAY_ON) begin
			disp_on = 1'b1;
		end else if (v >= OP_PAGE_BASE && v <= OP_PAGE_BASE + 8'd7) begin
			page_ptr = v[PAGE_W-1:0];
			col_ptr  = col_lo;
		end else if (v < OP_COL_HI_BASE) begin
			col_ptr = {col_ptr[COL_W-1:4], v[3:0]};
		end else if (v < OP_COL_HI_BASE + 8'h10) begin
			hi_col  = {v[3:0], col_ptr[3:0]};
			col_ptr = (int'(hi_col) >= WIDTH) ? COL_MAX : COL_W'(hi_col);
		end else if (v >= OP_START_LINE && v < OP_START_LINE + 8'h40) begin
			// start line has no effect on the image
		end else if (v == OP_NORMAL) begin
			disp_inv = 1'b0;
		end else if (v == OP_INVERSE) begin
			disp_inv = 1'b1;
		end else if (takes_argument(v)) begin
			pend_op   = v;
			arg_count = 1'b0;
		end
	endfunction

	// Advance the controller image by one item and return its result
	function automatic pixel_status_t predict_item(ocig_pkg::item_mode_t m, logic [7:0] b,
			logic [6:0] x, logic [5:0] y);
		pixel_status_t s;
		logic [7:0]    stored;
		s.pix = 1'b0;
		case (m)
			ocig_pkg::MODE_START, ocig_pkg::MODE_STOP: begin
				link_phase = PH_ADDRESS;
			end
			ocig_pkg::MODE_BYTE: begin
				if (link_phase == PH_ADDRESS) begin
					link_phase = PH_CONTROL;
				end else if (link_phase == PH_CONTROL) begin
					payload_data = b[CTRL_DATA_BIT];
					ctrl_repeat  = b[CTRL_CONT_BIT];
					link_phase   = PH_PAYLOAD;
				end else begin
					if (payload_data)
						store_pixel_byte(b);
					else
						run_command(b);
					if (ctrl_repeat)
						link_phase = PH_CONTROL;
				end
			end
			default: begin
				stored = (int'(x) < WIDTH) ? gram_img[int'(y[5:3]) * WIDTH + int'(x)] : 8'h00;
				s.pix  = disp_on && stored[y[2:0]];
				if (disp_inv && disp_on)
					s.pix = !s.pix;
			end
		endcase
		s.en  = disp_on;
		s.inv = disp_inv;
		return s;
	endfunction

	// ---------------------------------------------------------------- driving

	// Offer one item, wait for its handshake, record what it must produce
	task automatic send_item(ocig_pkg::item_mode_t m, logic [7:0] b, logic [6:0] x,
			logic [5:0] y, logic typed, pixel_status_t want);
		pixel_status_t model_status;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, y, x, b};
		s_axis_tuser  <= m;
		do
			@(posedge clk);
		while (!s_axis_tready);
		model_status = predict_item(m, b, x, y);
		expected_status.push_back(typed ? want : model_status);
		items_sent++;
		case (m)
			ocig_pkg::MODE_BYTE: bytes_sent++;
			ocig_pkg::MODE_READ: reads_sent++;
			default:             framing_sent++;
		endcase
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(ocig_pkg::MODE_BYTE, b, 7'($urandom), 6'($urandom), 1'b0, '0);
	endtask

	task automatic send_framing(ocig_pkg::item_mode_t m);
		send_item(m, 8'($urandom), 7'($urandom), 6'($urandom), 1'b0, '0);
	endtask

	task automatic send_read();
		send_item(ocig_pkg::MODE_READ, 8'($urandom), 7'($urandom), 6'($urandom), 1'b0, '0);
	endtask

	// Open a transfer: usually a start, then address, then a control byte of the given kind
	task automatic open_transfer(logic is_data, logic cont);
		logic [7:0] ctl;
		ctl = 8'($urandom);
		ctl[CTRL_DATA_BIT] = is_data;
		ctl[CTRL_CONT_BIT] = cont;
		if ($urandom_range(9) != 0)
			send_framing(ocig_pkg::MODE_START);
		send_byte(8'($urandom));
		send_byte(ctl);
	endtask

	function automatic logic [7:0] column_arg();
		return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(WIDTH - 1));
	endfunction

	// Append one random command with its arguments to cmd_bytes
	function automatic void queue_command();
		case ($urandom_range(15))
			0, 1: cmd_bytes.push_back(OP_DISPLAY_ON);
			2:    cmd_bytes.push_back(OP_DISPLAY_OFF);
			3:    cmd_bytes.push_back(OP_NORMAL);
			4:    cmd_bytes.push_back(OP_INVERSE);
			5:    cmd_bytes.push_back(OP_PAGE_BASE | 8'($urandom_range(7)));
			6:    cmd_bytes.push_back(OP_COL_LO_BASE | 8'($urandom_range(15)));
			7:    cmd_bytes.push_back(OP_COL_HI_BASE | 8'($urandom_range(15)));
			8:    cmd_bytes.push_back(OP_START_LINE | 8'($urandom_range(63)));
			9: begin
				cmd_bytes.push_back(OP_ADDR_MODE);
				cmd_bytes.push_back(8'($urandom));
			end
			10: begin
				cmd_bytes.push_back(OP_COL_WINDOW);
				cmd_bytes.push_back(column_arg());
				cmd_bytes.push_back(column_arg());
			end
			11: begin
				cmd_bytes.push_back(OP_PAGE_WINDOW);
				cmd_bytes.push_back(8'($urandom));
				cmd_bytes.push_back(8'($urandom));
			end
			12: begin
				case ($urandom_range(7))
					0:       cmd_bytes.push_back(OP_CONTRAST);
					1:       cmd_bytes.push_back(OP_CHARGE_PUMP);
					2:       cmd_bytes.push_back(OP_MUX_RATIO);
					3:       cmd_bytes.push_back(OP_DISP_OFFSET);
					4:       cmd_bytes.push_back(OP_CLOCK_DIV);
					5:       cmd_bytes.push_back(OP_PRECHARGE);
					6:       cmd_bytes.push_back(OP_COM_PINS);
					default: cmd_bytes.push_back(OP_VCOMH);
				endcase
				cmd_bytes.push_back(8'($urandom));
			end
			13: cmd_bytes.push_back(8'($urandom));
			14: begin
				cmd_bytes.push_back(OP_COL_WINDOW);
				cmd_bytes.push_back(8'h00);
				cmd_bytes.push_back(8'(WIDTH - 1));
			end
			default: begin
				cmd_bytes.push_back(OP_PAGE_WINDOW);
				cmd_bytes.push_back(8'h00);
				cmd_bytes.push_back(8'h07);
			end
		endcase
	endfunction

	// One random transaction: data run, command run, per-byte control run,
	// a burst of reads, or raw noise
	task automatic send_burst();
		int         kind;
		logic [7:0] ctl;
		kind = $urandom_range(99);
		if (kind < 35) begin
			open_transfer(1'b1, 1'b0);
			repeat ($urandom_range(16, 1)) begin
				if ($urandom_range(9) == 0)
					send_read();
				send_byte(8'($urandom));
			end
			if ($urandom_range(4) != 0)
				send_framing(ocig_pkg::MODE_STOP);
		end else if (kind < 65) begin
			open_transfer(1'b0, 1'b0);
			repeat ($urandom_range(4, 1))
				queue_command();
			while (cmd_bytes.size() != 0) begin
				if ($urandom_range(19) == 0)
					send_read();
				send_byte(cmd_bytes.pop_front());
			end
			if ($urandom_range(4) != 0)
				send_framing(ocig_pkg::MODE_STOP);
		end else if (kind < 78) begin
			// control byte ahead of every payload byte
			if ($urandom_range(9) != 0)
				send_framing(ocig_pkg::MODE_START);
			send_byte(8'($urandom));
			repeat ($urandom_range(6, 1)) begin
				if ($urandom_range(1) == 0)
					cmd_bytes.push_back(8'($urandom));
				else
					queue_command();
				ctl = 8'($urandom);
				ctl[CTRL_CONT_BIT] = 1'b1;
				ctl[CTRL_DATA_BIT] = (cmd_bytes.size() == 1) && ($urandom_range(1) == 0);
				while (cmd_bytes.size() != 0) begin
					send_byte(ctl);
					send_byte(cmd_bytes.pop_front());
				end
			end
			send_framing(ocig_pkg::MODE_STOP);
		end else if (kind < 93) begin
			repeat ($urandom_range(6, 1))
				send_read();
		end else begin
			repeat ($urandom_range(4, 1))
				send_item(ocig_pkg::item_mode_t'($urandom_range(3)), 8'($urandom),
					7'($urandom), 6'($urandom), 1'b0, '0);
		end
	endtask

	// Stop offering and wait until every predicted result has arrived
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	// Compare each accepted result with the oldest prediction; drive tready
	initial begin : result_check
		pixel_status_t got;
		pixel_status_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.pix = m_axis_tdata[0];
				got.en  = m_axis_tdata[1];
				got.inv = m_axis_tdata[2];
				if (expected_status.size() == 0) begin
					flag_error($sformatf("result %0d arrived with no item pending", results_seen));
				end else begin
					want = expected_status.pop_front();
					if (got.pix !== want.pix)
						flag_error($sformatf("result %0d pixel_on %0b, predicted %0b",
							results_seen, got.pix, want.pix));
					if (got.en !== want.en)
						flag_error($sformatf("result %0d panel_enabled %0b, predicted %0b",
							results_seen, got.en, want.en));
					if (got.inv !== want.inv)
						flag_error($sformatf("result %0d invert_active %0b, predicted %0b",
							results_seen, got.inv, want.inv));
				end
				if (got.pix === 1'b1)
					lit_pixels++;
				results_seen++;
			end
			// Hold off for a long stretch when asked, else stall at random
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		int phase_base;
		foreach (gram_img[i])
			gram_img[i] = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table, no idling
		foreach (directed_rows[i])
			send_item(directed_rows[i].m, directed_rows[i].b, directed_rows[i].x,
				directed_rows[i].y, directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		// Random phases: none after a long receiver hold, sender idle, receiver stall, both light
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
					hold_cycles  = LONG_HOLD;
				end
				1: begin
					tx_idle_pct  = 75;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 75;
				end
				default: begin
					tx_idle_pct  = 10;
					rx_stall_pct = 10;
				end
			endcase
			phase_base = items_sent;
			while (items_sent - phase_base < ITEMS_PER_PHASE)
				send_burst();
			drain_results();
		end

		repeat (8) @(posedge clk);
		$display("Covered %0d items: %0d bus bytes, %0d pixel reads, %0d starts/stops.",
			items_sent, bytes_sent, reads_sent, framing_sent);
		$display("Checked %0d results (%0d lit pixels) across four idling patterns.",
			results_seen, lit_pixels);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
